// ===== rtl/prsu_pkg.sv =====
package prsu_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_DATA_W   = 40;
    localparam int S_USER_W   = 3;
    localparam int M_DATA_W   = 48;

    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_START = 3'd1;
    localparam logic [2:0] KIND_STOP  = 3'd2;
    localparam logic [2:0] KIND_RSTUP = 3'd3;
    localparam logic [2:0] KIND_CLEAR = 3'd4;

    localparam logic [1:0] TANK_NONE = 2'd0;
    localparam logic [1:0] TANK_EST  = 2'd1;

    localparam logic [CFG_ADDR_W-1:0] REG_MAX_UPTIME = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TANK_MODE  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FLOW_RATE  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TANK_VOL   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_TANK_FILL  = 3'd4;

    localparam logic [9:0]  TANK_FILL_RESET = 10'd1000;
    localparam logic [9:0]  TANK_MARGIN     = 10'd50;
    localparam logic [9:0]  TANK_FALLBACK   = 10'd40;
    localparam logic [11:0] MS_HOUR_SCALE   = 12'd3600;

    typedef struct packed {
        logic capture;
        logic pre;
        logic main;
        logic fin;
    } prsu_cmd_t;

    typedef struct packed {
        logic out_free;
    } prsu_stat_t;

endpackage

// ===== rtl/prsu_ctrl.sv =====
module prsu_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  prsu_pkg::prsu_stat_t stat,
    output prsu_pkg::prsu_cmd_t  cmd
);
    import prsu_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE,
        ST_MUL1,
        ST_MAIN,
        ST_MUL2,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_PRE;
                end
            end
            ST_PRE: begin
                cmd.pre    = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                state_next = ST_MAIN;
            end
            ST_MAIN: begin
                cmd.main   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.fin = stat.out_free;
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/prsu_datapath.sv =====
module prsu_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  prsu_pkg::prsu_cmd_t                 cmd,
    output prsu_pkg::prsu_stat_t                stat,
    input  logic [prsu_pkg::S_DATA_W-1:0]       s_tdata,
    input  logic [prsu_pkg::S_USER_W-1:0]       s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [prsu_pkg::M_DATA_W-1:0]       m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [prsu_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [prsu_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import prsu_pkg::*;

    logic [31:0] max_uptime_reg, max_uptime_next;
    logic [1:0]  tank_mode_reg, tank_mode_next;
    logic [15:0] flow_rate_reg, flow_rate_next;
    logic [15:0] tank_vol_reg, tank_vol_next;
    logic [9:0]  tank_fill_reg, tank_fill_next;

    logic        pump_on_reg, pump_on_next;
    logic [31:0] run_time_reg, run_time_next;
    logic [31:0] last_stamp_reg, last_stamp_next;
    logic [31:0] limit_reg, limit_next;
    logic        fault_reg, fault_next;
    logic [3:0]  errs_reg, errs_next;
    logic        started_reg, started_next;
    logic        stopped_reg, stopped_next;
    logic        m_valid_reg, m_valid_next;

    logic [2:0]  kind_reg;
    logic [31:0] now_reg;
    logic        rst_reg, wstart_reg, wstop_reg, ipres_reg, ion_reg, lfull_reg, ack_reg;

    logic [21:0] room_part_reg;
    logic [37:0] room_reg;
    logic [47:0] used_reg;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    logic [9:0]  fill_excess;
    logic        ilk_ok;
    logic        tank;
    logic        tick_start;
    logic        pre_reset;
    logic        try_start;
    logic        can_start;
    logic        start_ok;
    logic        pon1;
    logic [31:0] last1;
    logic        hit;
    logic        bad;

    function automatic logic tank_check(
        input logic [1:0]  mode,
        input logic [15:0] flow,
        input logic [15:0] vol,
        input logic [9:0]  fill,
        input logic [47:0] used,
        input logic [37:0] room,
        input logic        lfull
    );
        logic res;
        case (mode)
            TANK_NONE: res = 1'b1;
            TANK_EST: begin
                if (flow == 16'd0 || vol == 16'd0) begin
                    res = fill > TANK_FALLBACK;
                end else if (fill <= TANK_MARGIN) begin
                    res = 1'b0;
                end else begin
                    res = used < {10'd0, room};
                end
            end
            default: res = lfull;
        endcase
        return res;
    endfunction

    assign fill_excess = tank_fill_reg - TANK_MARGIN;
    assign ilk_ok      = !ipres_reg || ion_reg;
    assign tank        = tank_check(tank_mode_reg, flow_rate_reg, tank_vol_reg, tank_fill_reg,
                                    used_reg, room_reg, lfull_reg);
    assign tick_start  = (kind_reg == KIND_TICK) && ilk_ok && wstart_reg && !pump_on_reg;
    assign pre_reset   = tick_start || (kind_reg == KIND_START && rst_reg)
                         || (kind_reg == KIND_RSTUP);
    assign try_start   = tick_start || (kind_reg == KIND_START);
    assign can_start   = !pump_on_reg && !fault_reg && tank && ilk_ok;
    assign start_ok    = try_start && can_start && ack_reg;
    assign pon1        = pump_on_reg || start_ok;
    assign last1       = start_ok ? now_reg : last_stamp_reg;
    assign hit         = (limit_reg != 32'd0) && (run_time_reg >= limit_reg);
    assign bad         = hit || !tank || (ipres_reg && !ion_reg);

    always_comb begin
        max_uptime_next = max_uptime_reg;
        tank_mode_next  = tank_mode_reg;
        flow_rate_next  = flow_rate_reg;
        tank_vol_next   = tank_vol_reg;
        tank_fill_next  = tank_fill_reg;
        pump_on_next    = pump_on_reg;
        run_time_next   = run_time_reg;
        last_stamp_next = last_stamp_reg;
        limit_next      = limit_reg;
        fault_next      = fault_reg;
        errs_next       = errs_reg;
        started_next    = started_reg;
        stopped_next    = stopped_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;

        if (cmd.pre) begin
            errs_next    = 4'd0;
            started_next = 1'b0;
            stopped_next = 1'b0;
            if (pre_reset) begin
                last_stamp_next = 32'd0;
                run_time_next   = 32'd0;
                limit_next      = max_uptime_reg;
            end
        end

        if (cmd.main) begin
            if (try_start) begin
                errs_next = {can_start && !ack_reg, !ilk_ok, !tank, fault_reg};
            end
            unique case (kind_reg)
                KIND_TICK: begin
                    pump_on_next    = pon1;
                    started_next    = start_ok;
                    last_stamp_next = last1;
                    if (pon1) begin
                        run_time_next = run_time_reg + (now_reg - last1);
                        if (wstop_reg && ack_reg) begin
                            pump_on_next = 1'b0;
                            stopped_next = 1'b1;
                        end else begin
                            last_stamp_next = now_reg;
                        end
                    end
                end
                KIND_START: begin
                    pump_on_next    = pon1;
                    started_next    = start_ok;
                    last_stamp_next = last1;
                end
                KIND_STOP: begin
                    if (pump_on_reg && ack_reg) begin
                        pump_on_next  = 1'b0;
                        run_time_next = run_time_reg + (now_reg - last_stamp_reg);
                        stopped_next  = 1'b1;
                    end
                end
                KIND_CLEAR: begin
                    if (fault_reg) begin
                        limit_next = limit_reg + max_uptime_reg;
                        fault_next = 1'b0;
                    end
                end
                default: ;
            endcase
        end

        if (cmd.fin) begin
            if (kind_reg == KIND_TICK && pump_on_reg) begin
                if (hit) begin
                    fault_next = 1'b1;
                end
                if (bad && ack_reg) begin
                    pump_on_next = 1'b0;
                    stopped_next = 1'b1;
                end
            end
            m_valid_next = 1'b1;
            m_data_next  = {7'd0, stopped_next, started_next, tank, run_time_next,
                            fault_next, errs_next, pump_on_next};
        end

        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_MAX_UPTIME: begin
                    max_uptime_next = cfg_wdata;
                    limit_next      = cfg_wdata;
                end
                REG_TANK_MODE: tank_mode_next = cfg_wdata[1:0];
                REG_FLOW_RATE: flow_rate_next = cfg_wdata[15:0];
                REG_TANK_VOL:  tank_vol_next  = cfg_wdata[15:0];
                REG_TANK_FILL: tank_fill_next = cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_uptime_reg <= 32'd0;
            tank_mode_reg  <= TANK_NONE;
            flow_rate_reg  <= 16'd0;
            tank_vol_reg   <= 16'd0;
            tank_fill_reg  <= TANK_FILL_RESET;
            pump_on_reg    <= 1'b0;
            run_time_reg   <= 32'd0;
            last_stamp_reg <= 32'd0;
            limit_reg      <= 32'd0;
            fault_reg      <= 1'b0;
            errs_reg       <= 4'd0;
            started_reg    <= 1'b0;
            stopped_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            max_uptime_reg <= max_uptime_next;
            tank_mode_reg  <= tank_mode_next;
            flow_rate_reg  <= flow_rate_next;
            tank_vol_reg   <= tank_vol_next;
            tank_fill_reg  <= tank_fill_next;
            pump_on_reg    <= pump_on_next;
            run_time_reg   <= run_time_next;
            last_stamp_reg <= last_stamp_next;
            limit_reg      <= limit_next;
            fault_reg      <= fault_next;
            errs_reg       <= errs_next;
            started_reg    <= started_next;
            stopped_reg    <= stopped_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg   <= s_tuser;
            now_reg    <= s_tdata[31:0];
            rst_reg    <= s_tdata[32];
            wstart_reg <= s_tdata[33];
            wstop_reg  <= s_tdata[34];
            ipres_reg  <= s_tdata[35];
            ion_reg    <= s_tdata[36];
            lfull_reg  <= s_tdata[37];
            ack_reg    <= s_tdata[38];
        end
        room_part_reg <= 22'({12'd0, fill_excess} * {10'd0, MS_HOUR_SCALE});
        room_reg      <= 38'({16'd0, room_part_reg} * {22'd0, tank_vol_reg});
        used_reg      <= {32'd0, flow_rate_reg} * {16'd0, run_time_reg};
        m_data_reg    <= m_data_next;
    end

    assign stat.out_free = !m_valid_reg || m_tready;
    assign m_tvalid      = m_valid_reg;
    assign m_tdata       = m_data_reg;

endmodule

// ===== rtl/pump_runtime_supervisor_unit.sv =====
// Run-time and safety supervisor for a dosing pump relay.
// s_ channel: one event item per handshake. s_tuser carries the event kind
//   (tick, start, stop, uptime reset, error clear); s_tdata the timestamp and
//   the sensed flags.
// m_ channel: exactly one result item per input item, in order.
// cfg_ port: write-only registers (max uptime, tank mode, flow rate, tank
//   volume, tank fill); the user must write them only while no item is in
//   flight, and the block itself does not enforce this.
// The sequencer steps through pre, mul1, main, mul2 and fin, and fin loads
//   the result once the output register is free. It works on one item at a
//   time and takes the next only after the result is loaded; mul1 and mul2
//   wait on the registered flow x run time multiply after each run-time update.
// The output register holds a finished result while m_tready is low, and the
//   sequencer waits in its final step until that register drains.
// Reset (aresetn low, synchronous): the pump is off, run time, stamp, limit
//   and the uptime fault are cleared, the registers take their reset values
//   and no result is pending.
module pump_runtime_supervisor_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // now_ms[31:0], reset_on_start, want_start, want_stop, interlock_present,
    // interlock_on, level_switch_full, relay_ack, pad
    input  logic [prsu_pkg::S_DATA_W-1:0]   s_tdata,
    // kind[2:0]
    input  logic [prsu_pkg::S_USER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // running, start_errors[3:0], uptime_fault, uptime_total[31:0], tank_ok,
    // started, stopped, pad
    output logic [prsu_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [prsu_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [prsu_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import prsu_pkg::*;

    prsu_cmd_t  cmd;
    prsu_stat_t stat;

    prsu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    prsu_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

endmodule

// ===== rtl/prsu_checker.sv =====
module prsu_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [prsu_pkg::S_DATA_W-1:0]   s_tdata,
    input logic [prsu_pkg::S_USER_W-1:0]   s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [prsu_pkg::M_DATA_W-1:0]   m_tdata,
    input logic                            cfg_wr_en,
    input logic [prsu_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input logic [prsu_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while another is in flight");

    a_stop_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[40] |-> !m_tdata[0])
        else $error("stopped item reports pump running");

    a_start_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[39] |-> m_tdata[4:1] == 4'd0 && (m_tdata[0] || m_tdata[40]))
        else $error("started item reports start errors or pump off");

endmodule

bind pump_runtime_supervisor_unit prsu_checker u_prsu_checker (.*);
